// File: sv/bpfb_pkg.sv
// Shared types, constants and helpers for the bit-packed frame builder.
// No dependencies; imported by every module of the block.
`default_nettype none
package bpfb_pkg;

  localparam int unsigned RES_MAX   = 3;   // most frame bytes one input item can produce
  localparam int unsigned CNT_W     = 2;   // width of a result count (0..3)
  localparam int unsigned ONES_W    = 11;  // running one-bit count
  localparam int unsigned IN_DATA_W = 24;  // packed input fields, padded to bytes

  localparam logic       MODE_START = 1'b0;
  localparam logic       MODE_DATA  = 1'b1;

  // One accepted item's worth of frame bytes, handed from core to serialiser.
  typedef struct packed {
    logic                          valid;
    logic [CNT_W-1:0]              cnt;
    logic [RES_MAX-1:0][7:0]       bytes;
  } grp_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/bit_packed_frame_builder_top.sv
// Top level of the bit-packed frame builder: input stream, packing core, output slot.
// Depends on bpfb_pkg, bpfb_core and bpfb_serial.
//
// Usage:
//  - Input stream (in_*): tuser is the item kind, 0 = start, 1 = data byte.
//    A start transfer carries cmd, ttl and msg_length; msg_length data
//    transfers follow. Data transfers outside a message are dropped.
//  - Output stream (out_*): one frame byte per transfer in tdata[7:0]; tlast
//    marks the checksum byte that closes a frame.
//  - Path: an item's bytes pass the core register, then the output slot, before
//    out_tvalid rises for its first byte.
//  - Throughput: one input item per cycle while each yields one byte and out_tready
//    stays high. The last data item and an empty start yield three bytes, which hold
//    the output slot until all three have transferred; the core register still takes
//    the next item meanwhile, so the input stalls only once both are full.
//  - Receiver stall: out_tready low holds the current byte; the core and
//    then in_tready back up behind it. Nothing is dropped.
//  - Reset (rst_n low, synchronous): no message open, counts cleared, both
//    stages empty.
`default_nettype none
module bit_packed_frame_builder_top
  import bpfb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,  // cmd[2:0], ttl[6:3], msg_length[13:7],
                                               // data_byte[21:14], zero pad[23:22]
  input  wire logic                 in_tuser,  // mode
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata, // out_byte[7:0]
  output logic                      out_tlast
);

  grp_t grp;
  logic grp_take;
  logic grp_free;
  logic in_acc;

  assign in_tready = grp_free;
  assign in_acc    = in_tvalid && in_tready;

  bpfb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .mode       (in_tuser),
    .cmd        (in_tdata[2:0]),
    .ttl        (in_tdata[6:3]),
    .msg_length (in_tdata[13:7]),
    .data_byte  (in_tdata[21:14]),
    .grp_take   (grp_take),
    .grp_free   (grp_free),
    .grp        (grp)
  );

  bpfb_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp        (grp),
    .grp_take   (grp_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// File: sv/bpfb_core.sv
// Frame state and per-item packing logic; registers one group of up to three bytes.
// Depends on bpfb_pkg.
`default_nettype none
module bpfb_core
  import bpfb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_acc,
  input  wire logic             mode,
  input  wire logic [2:0]       cmd,
  input  wire logic [3:0]       ttl,
  input  wire logic [6:0]       msg_length,
  input  wire logic [7:0]       data_byte,
  input  wire logic             grp_take,
  output logic                  grp_free,
  output grp_t                  grp
);

  logic              in_msg_r, in_msg_nxt;
  logic [6:0]        bl_r, bl_nxt;
  logic [5:0]        held_r, held_nxt;
  logic [ONES_W-1:0] ones_r, ones_nxt;
  grp_t              grp_r, grp_nxt;

  logic [7:0]        hdr;
  logic [3:0]        hdr_pop;
  logic [7:0]        dbyte;
  logic [ONES_W-1:0] ones1, ones2;
  logic [6:0]        bl_dec;

  assign grp_free = !grp_r.valid || grp_take;
  assign grp      = grp_r;

  always_comb begin
    hdr     = {msg_length[0], ttl, cmd};
    hdr_pop = pop8(hdr);
    dbyte   = {data_byte[1:0], held_r};
    ones1   = ones_r + {{(ONES_W-4){1'b0}}, pop8(dbyte)};
    ones2   = ones1 + {{(ONES_W-4){1'b0}}, pop8({2'b00, data_byte[7:2]})};
    bl_dec  = bl_r - 7'd1;

    in_msg_nxt = in_msg_r;
    bl_nxt     = bl_r;
    held_nxt   = held_r;
    ones_nxt   = ones_r;
    grp_nxt    = grp_r;
    if (grp_take) begin
      grp_nxt.valid = 1'b0;
    end

    if (in_acc) begin
      if (mode == MODE_START) begin
        ones_nxt         = {{(ONES_W-4){1'b0}}, hdr_pop};
        grp_nxt.valid    = 1'b1;
        grp_nxt.bytes[0] = hdr;
        if (msg_length == 7'd0) begin
          // empty message: header, count low bits, count byte
          grp_nxt.cnt      = CNT_W'(RES_MAX);
          grp_nxt.bytes[1] = {hdr_pop[1:0], 6'd0};
          grp_nxt.bytes[2] = {6'd0, hdr_pop[3:2]};
          in_msg_nxt       = 1'b0;
          bl_nxt           = 7'd0;
          held_nxt         = 6'd0;
        end else begin
          grp_nxt.cnt = CNT_W'(1);
          in_msg_nxt  = 1'b1;
          bl_nxt      = msg_length;
          held_nxt    = msg_length[6:1];
        end
      end else if (in_msg_r) begin
        grp_nxt.valid    = 1'b1;
        grp_nxt.bytes[0] = dbyte;
        bl_nxt           = bl_dec;
        if (bl_dec == 7'd0) begin
          grp_nxt.cnt      = CNT_W'(RES_MAX);
          grp_nxt.bytes[1] = {ones2[1:0], data_byte[7:2]};
          grp_nxt.bytes[2] = ones2[9:2];
          ones_nxt         = ones2;
          in_msg_nxt       = 1'b0;
          held_nxt         = 6'd0;
        end else begin
          grp_nxt.cnt = CNT_W'(1);
          ones_nxt    = ones1;
          held_nxt    = data_byte[7:2];
        end
      end
      // data outside a message: dropped, nothing changes
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      bl_r     <= 7'd0;
      held_r   <= 6'd0;
      ones_r   <= '0;
      grp_r    <= '0;
    end else begin
      in_msg_r <= in_msg_nxt;
      bl_r     <= bl_nxt;
      held_r   <= held_nxt;
      ones_r   <= ones_nxt;
      grp_r    <= grp_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/bpfb_serial.sv
// Output slot: holds one byte group and hands it out one transfer per cycle while out_tready is high.
// Depends on bpfb_pkg.
`default_nettype none
module bpfb_serial
  import bpfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire grp_t        grp,
  output logic             grp_take,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  grp_t             slot_r, slot_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             last;

  assign last       = idx_r == (slot_r.cnt - CNT_W'(1));
  assign grp_take   = grp.valid && (!slot_r.valid || (out_tready && last));
  assign out_tvalid = slot_r.valid;
  assign out_tdata  = slot_r.bytes[idx_r];
  assign out_tlast  = idx_r == CNT_W'(RES_MAX - 1);

  always_comb begin
    slot_nxt = slot_r;
    idx_nxt  = idx_r;
    if (slot_r.valid && out_tready) begin
      if (last) begin
        slot_nxt.valid = 1'b0;
        idx_nxt        = '0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
    if (grp_take) begin
      slot_nxt = grp;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      idx_r  <= '0;
    end else begin
      slot_r <= slot_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// File: tb/bit_packed_frame_builder_top_tb.sv
// Self-checking testbench for bit_packed_frame_builder_top: a queued stream driver, a
// bursty sender and a stalling receiver, with frame bytes predicted in the bench itself.
// Depends on bpfb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module bit_packed_frame_builder_top_tb;
  import bpfb_pkg::*;

  localparam int ITEMS_TARGET = 280;   // counted input transfers for the stimulus
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES  = 16;    // settle time after the last expected byte
  localparam int REPORT_CAP   = 30;    // mismatch lines printed before going quiet

  // One input item as the block sees it; hold_for_drain makes the driver wait
  // until every predicted byte has come out before offering this item.
  typedef struct {
    logic       mode;
    logic [2:0] cmd;
    logic [3:0] ttl;
    logic [6:0] len;
    logic [7:0] dbyte;
    bit         hold_for_drain;
  } in_item_t;

  typedef struct {
    logic [7:0] val;
    logic       last;
  } frame_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;  // cmd, ttl, msg_length, data_byte, pad
  logic                 in_tuser = 1'b0;  // mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;  // out_byte
  logic                 out_tlast;  // frame_end

  bit_packed_frame_builder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus store and prediction state
  // ---------------------------------------------------------------------------
  in_item_t    items_to_send_q[$];
  frame_byte_t frame_bytes_q[$];   // predicted frame bytes, oldest first

  // mirror of the packer's state
  logic        pk_open = 1'b0;
  logic [6:0]  pk_left = '0;
  logic [5:0]  pk_held = '0;
  logic [10:0] pk_ones = '0;

  int n_queued     = 0;
  int n_in_xfers   = 0;
  int n_out_xfers  = 0;
  int n_frames     = 0;
  int n_errors     = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= REPORT_CAP)
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic push_frame_byte(input logic [7:0] v, input logic last);
    frame_byte_t fb;
    fb.val  = v;
    fb.last = last;
    frame_bytes_q.push_back(fb);
  endtask

  // Works out the frame bytes one accepted item produces and updates the mirror.
  task automatic predict_frame_bytes(input in_item_t it);
    logic [7:0] b;
    if (it.mode == MODE_START) begin
      b = {it.len[0], it.ttl, it.cmd};
      pk_ones = 11'($countones(b));
      push_frame_byte(b, 1'b0);
      if (it.len == 7'd0) begin
        // empty message: checksum bits and checksum byte straight away
        push_frame_byte({pk_ones[1:0], 6'd0}, 1'b0);
        push_frame_byte(pk_ones[9:2], 1'b1);
        pk_open = 1'b0;
        pk_left = '0;
        pk_held = '0;
      end else begin
        // a start while open simply drops the old message
        pk_open = 1'b1;
        pk_left = it.len;
        pk_held = it.len[6:1];
      end
    end else if (pk_open) begin
      b = {it.dbyte[1:0], pk_held};
      pk_ones = pk_ones + 11'($countones(b));
      push_frame_byte(b, 1'b0);
      pk_held = it.dbyte[7:2];
      pk_left = pk_left - 7'd1;
      if (pk_left == 7'd0) begin
        pk_ones = pk_ones + 11'($countones(pk_held));
        push_frame_byte({pk_ones[1:0], pk_held}, 1'b0);
        push_frame_byte(pk_ones[9:2], 1'b1);
        pk_open = 1'b0;
        pk_held = '0;
      end
    end
    // data outside a message: nothing comes out
  endtask

  // ---------------------------------------------------------------------------
  // Item builders; unused fields carry random junk so every field bit toggles
  // ---------------------------------------------------------------------------
  task automatic add_start(input logic [2:0] c, input logic [3:0] t, input logic [6:0] l,
                           input bit hold);
    in_item_t it;
    it.mode           = MODE_START;
    it.cmd            = c;
    it.ttl            = t;
    it.len            = l;
    it.dbyte          = 8'($urandom);
    it.hold_for_drain = hold;
    items_to_send_q.push_back(it);
    n_queued++;
  endtask

  task automatic add_data(input logic [7:0] d, input bit counted);
    in_item_t it;
    it.mode           = MODE_DATA;
    it.cmd            = 3'($urandom);
    it.ttl            = 4'($urandom);
    it.len            = 7'($urandom);
    it.dbyte          = d;
    it.hold_for_drain = 1'b0;
    items_to_send_q.push_back(it);
    if (counted)
      n_queued++;
  endtask

  // whole well-formed frame with random header and payload
  task automatic add_frame(input logic [6:0] l, input bit hold);
    add_start(3'($urandom), 4'($urandom), l, hold);
    for (int i = 0; i < l; i++)
      add_data(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  in_item_t cur_item;
  int       burst_left = 4;
  int       gap_left   = 0;

  always @(posedge clk) begin : drive_p
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_bytes(cur_item);
        n_in_xfers++;
      end
      offer = in_tvalid && !in_tready;  // an unaccepted item stays put
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_to_send_q.size() != 0 &&
                     !(items_to_send_q[0].hold_for_drain && frame_bytes_q.size() != 0)) begin
          cur_item = items_to_send_q.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            // roughly a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end
        end
      end
      in_tvalid <= offer;
      in_tuser  <= cur_item.mode;
      in_tdata  <= {2'b00, cur_item.dbyte, cur_item.len, cur_item.ttl, cur_item.cmd};
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall style is picked anew whenever rx_phase[5:0] wraps to zero
  // ---------------------------------------------------------------------------
  logic [7:0] rx_phase = '0;
  int         rx_style = 0;

  always @(posedge clk) begin : receive_p
    logic rdy;
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase[5:0] == 6'd0)
      rx_style = $urandom_range(0, 3);
    case (rx_style)
      0: begin
        rdy = 1'b1;
      end
      1: begin
        rdy = ($urandom_range(0, 3) != 0);
      end
      2: begin
        rdy = (rx_phase % 3 == 0);
      end
      default: begin
        rdy = 1'($urandom_range(0, 1));
      end
    endcase
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: each output transfer against the oldest predicted byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_p
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_out_xfers++;
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("unexpected frame byte", out_tdata, 0);
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_tdata !== want.val)
          report_mismatch("out_byte", out_tdata, want.val);
        if (out_tlast !== want.last)
          report_mismatch("frame_end", out_tlast, want.last);
        if (want.last)
          n_frames++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer means the block has hung
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still due",
               STALL_LIMIT, frame_bytes_q.size());
      $display("bit_packed_frame_builder_top_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_p
    int   pick;
    int   l;
    bit   big_done;
    bit   first_rand;
    big_done   = 1'b0;
    first_rand = 1'b1;

    // directed: stray data while idle is dropped
    add_data(8'hFF, 1'b0);
    // empty messages at both header extremes
    add_start(3'd0, 4'd0, 7'd0, 1'b0);
    add_start(3'd7, 4'd15, 7'd0, 1'b0);
    // single-byte message, all ones
    add_start(3'd7, 4'd15, 7'd1, 1'b0);
    add_data(8'hFF, 1'b1);
    // two bytes, all zeros then mixed
    add_start(3'd5, 4'd10, 7'd2, 1'b1);
    add_data(8'h00, 1'b1);
    add_data(8'hA5, 1'b1);
    // message abandoned by a fresh start partway through
    add_start(3'd2, 4'd6, 7'd3, 1'b0);
    add_data(8'h3C, 1'b1);
    add_start(3'd1, 4'd9, 7'd2, 1'b0);
    add_data(8'h55, 1'b1);
    add_data(8'hAA, 1'b1);
    // stray data after a closed frame
    add_data(8'h81, 1'b0);
    add_data(8'h7E, 1'b0);

    // random part: mostly whole frames, some broken ones and noise
    while (n_queued < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!big_done && n_queued > 110) begin
        add_frame(7'd127, 1'b1);  // longest message, once
        big_done = 1'b1;
      end else if (pick < 78) begin
        l = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        add_frame(7'(l), first_rand || ($urandom_range(0, 24) == 0));
        first_rand = 1'b0;
      end else if (pick < 90) begin
        // cut short: fewer data bytes than announced, next start drops it
        l = $urandom_range(2, 12);
        add_start(3'($urandom), 4'($urandom), 7'(l), 1'b0);
        repeat ($urandom_range(0, l - 1))
          add_data(8'($urandom), 1'b1);
        add_frame(7'($urandom_range(1, 6)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 3))
          add_data(8'($urandom), 1'b0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (items_to_send_q.size() != 0 || in_tvalid || frame_bytes_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers and %0d frame bytes over %0d closed frames,",
             n_in_xfers, n_out_xfers, n_frames);
    $display("including empty, single-byte, abandoned and 127-byte messages and stray data.");
    if (n_errors == 0) begin
      $display("bit_packed_frame_builder_top_tb: PASS");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("bit_packed_frame_builder_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bpfb_pkg.sv
sv/bpfb_core.sv
sv/bpfb_serial.sv
sv/bit_packed_frame_builder_top.sv
tb/bit_packed_frame_builder_top_tb.sv
